// File: rtl/assert_macros.svh
// Shared assertion macros. Both expect signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/asidp_pkg.sv
package asidp_pkg;

  localparam int ASID_NUM_DEF = 256;
  localparam int PAGE_LOG2    = 12;
  localparam int ADDR_W       = 32;
  localparam int ASID_W       = 8;

  localparam logic [ADDR_W-1:0] BASE_VIRT_RST = 32'd4096;

  localparam logic [1:0] CMD_CREATE    = 2'd0;
  localparam logic [1:0] CMD_DESTROY   = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_UNALIGNED = 3'd1;
  localparam logic [2:0] STATUS_NOMAP     = 3'd2;
  localparam logic [2:0] STATUS_NOASID    = 3'd3;
  localparam logic [2:0] STATUS_BAD       = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ASID_W-1:0] asid_in;
    logic [ADDR_W-1:0] size_bytes;
    logic [ADDR_W-1:0] phys_base;
    logic [ADDR_W-1:0] virt_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ASID_W-1:0] asid_out;
    logic [ADDR_W-1:0] phys_addr;
    logic              tlb_invalidate;
  } rsp_t;

  // One address-space table entry.
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] phys;
  } tbl_entry_t;

  typedef struct packed {
    logic init;  // clearing pass: write entry init_idx
    logic rd;    // read entry at top of stack
    logic pop;
    logic push;
  } pool_ctl_t;

  typedef struct packed {
    logic empty;  // no free ASID left
    logic full;   // nothing handed out
  } pool_stat_t;

endpackage

// File: rtl/asidp_ram.sv
module asidp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/asidp_pool.sv
`include "assert_macros.svh"

// LIFO of free ASIDs. Entries below top are handed out; entry at top is next.
module asidp_pool #(
  parameter int ASID_NUM = asidp_pkg::ASID_NUM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  asidp_pkg::pool_ctl_t        ctl,
  input  logic [$clog2(ASID_NUM)-1:0] init_idx,
  input  logic [$clog2(ASID_NUM)-1:0] push_asid,
  output logic [$clog2(ASID_NUM)-1:0] top_asid,
  output asidp_pkg::pool_stat_t       stat
);

  localparam int AW = $clog2(ASID_NUM);
  localparam int PW = $clog2(ASID_NUM - 1);
  localparam logic [AW-1:0] TOP_MAX = AW'(ASID_NUM - 1);

  logic [AW-1:0] top;
  logic [AW-1:0] top_dec;
  logic          we;
  logic [PW-1:0] waddr;
  logic [AW-1:0] wdata;

  assign top_dec = top - AW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = top_dec[PW-1:0];
    wdata = push_asid;
    if (ctl.init) begin
      // entry i starts out holding ASID i+1; last index has no entry
      we    = (init_idx != TOP_MAX);
      waddr = init_idx[PW-1:0];
      wdata = init_idx + AW'(1);
    end else if (ctl.push) begin
      we = 1'b1;
    end
  end

  asidp_ram #(
    .WIDTH (AW),
    .DEPTH (ASID_NUM - 1)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd),
    .raddr (top[PW-1:0]),
    .rdata (top_asid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (ctl.pop) begin
      top <= top + AW'(1);
    end else if (ctl.push) begin
      top <= top_dec;
    end
  end

  assign stat.empty = (top == TOP_MAX);
  assign stat.full  = (top == '0);

  `ASSERT_NEVER(a_pop_empty, ctl.pop && stat.empty, "pop from empty ASID pool")
  `ASSERT_NEVER(a_push_full, ctl.push && stat.full, "push onto full ASID pool")
  `ASSERT_NEVER(a_pop_push, ctl.pop && ctl.push, "pop and push in one cycle")

endmodule

// File: rtl/address_space_table_with_asid_pool_unit.sv
//  channel   direction  handshake              payload
//  command   in         start / busy           req  (asidp_pkg::req_t)
//  result    out        done strobe, 1 cycle   rsp  (asidp_pkg::rsp_t)
//  config    in         cfg_valid / cfg_ready  cfg_data (base_virt)
//
//  A command is taken when start is high and busy is low. Its result shows
//  on rsp with done high, registered after the execute state, for exactly
//  one cycle. Busy is high in the execute state (table and pool read, then
//  read-modify-write), so a new command waits for the last one. After reset
//  the clearing pass sweeps all ASID_NUM entries (256 by default), resetting
//  live flags and loading the free pool; busy is high meanwhile. The result
//  side cannot stall; cfg writes are always ready.
`include "assert_macros.svh"

module address_space_table_with_asid_pool_unit #(
  parameter int ASID_NUM = asidp_pkg::ASID_NUM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  asidp_pkg::req_t                 req,
  output logic                            done,
  output asidp_pkg::rsp_t                 rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [asidp_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int AW = $clog2(ASID_NUM);
  localparam int TW = $bits(asidp_pkg::tbl_entry_t);
  localparam logic [AW-1:0] CLR_LAST = AW'(ASID_NUM - 1);

  asidp_pkg::state_t state, state_next;

  logic                         accept;
  logic [AW-1:0]                clr_idx;
  logic [asidp_pkg::ADDR_W-1:0] base_virt;

  // command held for the execute cycle
  asidp_pkg::req_t              req_q;
  logic                         asid_ok_q;   // nonzero and inside the table
  logic [asidp_pkg::ADDR_W-1:0] off_q;       // virt - base_virt
  logic                         under_q;     // virt below base_virt
  logic [AW-1:0]                asid_idx;

  // memory ports
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr;
  asidp_pkg::tbl_entry_t tbl_wdata;
  asidp_pkg::tbl_entry_t tbl_rdata;
  logic [TW-1:0]         tbl_rbits;

  asidp_pkg::pool_ctl_t  pool_ctl;
  asidp_pkg::pool_stat_t pool_stat;
  logic [AW-1:0]         pool_asid;

  // execute-cycle decisions
  asidp_pkg::rsp_t       ex_rsp;
  logic                  ex_pop;
  logic                  ex_push;
  logic                  ex_tbl_we;
  logic [AW-1:0]         ex_tbl_addr;
  asidp_pkg::tbl_entry_t ex_tbl_data;
  logic                  live;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign asid_idx  = AW'(req_q.asid_in);

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= asidp_pkg::S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == asidp_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      asidp_pkg::S_CLEAR: begin
        if (clr_idx == CLR_LAST) begin
          state_next = asidp_pkg::S_IDLE;
        end
      end
      asidp_pkg::S_IDLE: begin
        if (start) begin
          state_next = asidp_pkg::S_EXEC;
        end
      end
      asidp_pkg::S_EXEC: begin
        state_next = asidp_pkg::S_IDLE;
      end
      default: begin
        state_next = asidp_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    tbl_we    = 1'b0;
    tbl_waddr = clr_idx;
    tbl_wdata = '0;
    pool_ctl  = '0;
    unique case (state)
      asidp_pkg::S_CLEAR: begin
        tbl_we        = 1'b1;
        pool_ctl.init = 1'b1;
      end
      asidp_pkg::S_IDLE: begin
        busy        = 1'b0;
        pool_ctl.rd = start;
      end
      asidp_pkg::S_EXEC: begin
        tbl_we        = ex_tbl_we;
        tbl_waddr     = ex_tbl_addr;
        tbl_wdata     = ex_tbl_data;
        pool_ctl.pop  = ex_pop;
        pool_ctl.push = ex_push;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------- config and command capture ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_virt <= asidp_pkg::BASE_VIRT_RST;
    end else if (cfg_valid && cfg_ready) begin
      base_virt <= cfg_data;
    end
  end

  // window offset is formed at capture so execute has one add and one compare
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= req;
      asid_ok_q <= (req.asid_in != '0) && (32'(req.asid_in) < 32'(ASID_NUM));
      off_q     <= req.virt_addr - base_virt;
      under_q   <= req.virt_addr < base_virt;
    end
  end

  // ---------------- memories ----------------
  asidp_ram #(
    .WIDTH (TW),
    .DEPTH (ASID_NUM)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (AW'(req.asid_in)),
    .rdata (tbl_rbits)
  );

  assign tbl_rdata = tbl_rbits;

  asidp_pool #(
    .ASID_NUM (ASID_NUM)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pool_ctl),
    .init_idx  (clr_idx),
    .push_asid (asid_idx),
    .top_asid  (pool_asid),
    .stat      (pool_stat)
  );

  // ---------------- execute: read data is valid here ----------------
  assign live = asid_ok_q && tbl_rdata.live;

  always_comb begin
    ex_rsp      = '0;
    ex_rsp.status = asidp_pkg::STATUS_BAD;
    ex_pop      = 1'b0;
    ex_push     = 1'b0;
    ex_tbl_we   = 1'b0;
    ex_tbl_addr = asid_idx;
    ex_tbl_data = tbl_rdata;
    case (req_q.cmd)
      asidp_pkg::CMD_CREATE: begin
        // alignment is checked before pool exhaustion
        if (req_q.size_bytes[asidp_pkg::PAGE_LOG2-1:0] != '0) begin
          ex_rsp.status = asidp_pkg::STATUS_UNALIGNED;
        end else if (pool_stat.empty) begin
          ex_rsp.status = asidp_pkg::STATUS_NOASID;
        end else begin
          ex_rsp.status    = asidp_pkg::STATUS_OK;
          ex_rsp.asid_out  = asidp_pkg::ASID_W'(pool_asid);
          ex_pop           = 1'b1;
          ex_tbl_we        = 1'b1;
          ex_tbl_addr      = pool_asid;
          ex_tbl_data.live = 1'b1;
          ex_tbl_data.size = req_q.size_bytes;
          ex_tbl_data.phys = req_q.phys_base;
        end
      end
      asidp_pkg::CMD_DESTROY: begin
        if (live && !pool_stat.full) begin
          ex_rsp.status         = asidp_pkg::STATUS_OK;
          ex_rsp.asid_out       = req_q.asid_in;
          ex_rsp.tlb_invalidate = 1'b1;
          ex_push               = 1'b1;
          ex_tbl_we             = 1'b1;
          ex_tbl_data.live      = 1'b0;
        end
      end
      asidp_pkg::CMD_TRANSLATE: begin
        if (live) begin
          if (req_q.virt_addr[asidp_pkg::PAGE_LOG2-1:0] != '0) begin
            ex_rsp.status = asidp_pkg::STATUS_UNALIGNED;
          end else if (under_q || (off_q >= tbl_rdata.size)) begin
            ex_rsp.status = asidp_pkg::STATUS_NOMAP;
          end else begin
            ex_rsp.status    = asidp_pkg::STATUS_OK;
            ex_rsp.phys_addr = tbl_rdata.phys + off_q;
          end
        end
      end
      default: begin
        ex_rsp.status = asidp_pkg::STATUS_BAD;
      end
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == asidp_pkg::S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == asidp_pkg::S_EXEC) begin
      rsp <= ex_rsp;
    end
  end

  `ASSERT_CLK(a_fixed_latency, accept |=> ##1 done, "transfer without result")
  `ASSERT_CLK(a_inval_ok,
      done && rsp.tlb_invalidate |-> rsp.status == asidp_pkg::STATUS_OK && rsp.asid_out != '0,
      "invalidate on failed destroy")
  `ASSERT_CLK(a_paddr_ok,
      done && rsp.phys_addr != '0 |-> rsp.status == asidp_pkg::STATUS_OK && rsp.asid_out == '0,
      "address on failed translate")

endmodule
